@@ src/nnus_pkg.sv @@
`timescale 1ns / 1ps

package nnus_pkg;

  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned ScaleW      = 4;
  localparam int unsigned RowW        = 12;
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned TgtWidthW   = CfgDataW + ScaleW;
  localparam int unsigned AddrW       = 30;
  localparam int unsigned PixelW      = 32;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SCALE  = 2'd2
  } cfg_idx_e;

  // one source pixel block, ready for replication
  typedef struct packed {
    logic [PixelW-1:0]    pix;
    logic [AddrW-1:0]     base;
    logic [TgtWidthW-1:0] tw;
  } blk_t;

endpackage

@@ src/nearest_neighbor_upscale_writer.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// pixel    in         pixel_valid_i/pixel_ready_o pixel_word_i
// out      out        out_valid_o/out_ready_i     target_address_o, pixel_value_o,
//                                                 last_of_block_o
// cfg      in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// A non-zero pixel yields scale*scale writes from the output register, one per cycle
// while out_ready_i is high; a zero pixel is accepted and yields no transaction.
// First write leaves after its pixel passes the counter/product stage, the address
// multiply stage and the output register. Reset clears the counters and valid flags
// and sets width, height and scale to 1; config waits for an idle pipeline.
// Output stalls back up through the two internal stages before pixel_ready_o drops.

module nearest_neighbor_upscale_writer #(
  parameter int unsigned MAX_SCALE = 8,
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pixel_valid_i,
  output logic                               pixel_ready_o,
  input  logic [nnus_pkg::PixelW-1:0]        pixel_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [nnus_pkg::AddrW-1:0]         target_address_o,
  output logic [nnus_pkg::PixelW-1:0]        pixel_value_o,
  output logic                               last_of_block_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nnus_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [nnus_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMPW = (CW >= nnus_pkg::CfgDataW) ? CW + 1 : nnus_pkg::CfgDataW + 1;
  localparam int unsigned CSW  = CW + nnus_pkg::ScaleW;
  localparam int unsigned RSW  = nnus_pkg::RowW + nnus_pkg::ScaleW;
  localparam int unsigned RW   = nnus_pkg::RowW;
  localparam int unsigned DW   = nnus_pkg::CfgDataW;
  localparam int unsigned SCW  = nnus_pkg::ScaleW;
  localparam int unsigned TWW  = nnus_pkg::TgtWidthW;
  localparam int unsigned AW   = nnus_pkg::AddrW;

  // configuration, stored already clamped
  logic [DW-1:0]  w_q, h_q;
  logic [SCW-1:0] s_q;
  logic [DW-1:0]  w_clamp, h_clamp;
  logic [SCW-1:0] s_clamp;

  // source position
  logic [CW-1:0]   col_q, col_d, col_in;
  logic [RW-1:0]   row_q, row_d, row_in;
  logic            wrap_col;
  logic [RW:0]     row_t, row_n;
  logic [CMPW-1:0] col_n;

  // stage A: products
  logic                          a_valid_q;
  logic [nnus_pkg::PixelW-1:0]   a_pix_q;
  logic [RSW-1:0]                a_rs_q;
  logic [CSW-1:0]                a_cs_q;
  logic [TWW-1:0]                a_tw_q;

  // stage B: block base address
  logic                          b_valid_q;
  nnus_pkg::blk_t                b_blk_q;

  logic in_fire, a_free, a_adv, b_free, b_adv;

  // a pixel offered or in flight holds off register writes
  assign cfg_ready_o = ~(pixel_valid_i | a_valid_q | b_valid_q | out_valid_o);

  always_comb begin
    if (cfg_data_i == '0) begin
      w_clamp = DW'(1);
    end else if (CMPW'(cfg_data_i) > CMPW'(MAX_WIDTH)) begin
      w_clamp = DW'(MAX_WIDTH);
    end else begin
      w_clamp = cfg_data_i;
    end
    if (cfg_data_i == '0) begin
      h_clamp = DW'(1);
    end else if (cfg_data_i > DW'(nnus_pkg::HeightLimit)) begin
      h_clamp = DW'(nnus_pkg::HeightLimit);
    end else begin
      h_clamp = cfg_data_i;
    end
    if (cfg_data_i[SCW-1:0] == '0) begin
      s_clamp = SCW'(1);
    end else if (cfg_data_i[SCW-1:0] > SCW'(MAX_SCALE)) begin
      s_clamp = SCW'(MAX_SCALE);
    end else begin
      s_clamp = cfg_data_i[SCW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= DW'(1);
      h_q <= DW'(1);
      s_q <= SCW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (nnus_pkg::cfg_idx_e'(cfg_index_i))
        nnus_pkg::CFG_WIDTH:  w_q <= w_clamp;
        nnus_pkg::CFG_HEIGHT: h_q <= h_clamp;
        nnus_pkg::CFG_SCALE:  s_q <= s_clamp;
        default: ;
      endcase
    end
  end

  // pipeline flow
  nnus_pkg::blk_t next_blk;
  logic           blk_take;

  assign b_adv         = blk_take;
  assign b_free        = ~b_valid_q | b_adv;
  assign a_adv         = a_valid_q & b_free;
  assign a_free        = ~a_valid_q | a_adv;
  assign pixel_ready_o = a_free;
  assign in_fire       = pixel_valid_i & a_free;

  // position of the incoming pixel and of the one after it
  always_comb begin
    wrap_col = (CMPW'(col_q) >= CMPW'(w_q));
    col_in   = wrap_col ? '0 : col_q;
    row_t    = wrap_col ? ({1'b0, row_q} + (RW+1)'(1)) : {1'b0, row_q};
    row_in   = (DW'(row_t) >= h_q) ? '0 : row_t[RW-1:0];
    col_n    = CMPW'(col_in) + CMPW'(1);
    row_n    = {1'b0, row_in} + (RW+1)'(1);
    if (col_n >= CMPW'(w_q)) begin
      col_d = '0;
      row_d = (DW'(row_n) >= h_q) ? '0 : row_n[RW-1:0];
    end else begin
      col_d = col_n[CW-1:0];
      row_d = row_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (a_free) begin
        a_valid_q <= in_fire & (pixel_word_i != '0);
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_pix_q <= pixel_word_i;
      a_rs_q  <= RSW'(row_in) * RSW'(s_q);
      a_cs_q  <= CSW'(col_in) * CSW'(s_q);
      a_tw_q  <= TWW'(w_q) * TWW'(s_q);
    end
    if (b_free) begin
      b_blk_q <= next_blk;
    end
  end

  always_comb begin
    next_blk.pix  = a_pix_q;
    next_blk.base = AW'(a_rs_q) * AW'(a_tw_q) + AW'(a_cs_q);
    next_blk.tw   = a_tw_q;
  end

  nnus_emitter #(
    .MAX_SCALE (MAX_SCALE)
  ) u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .scale_i          (s_q),
    .blk_valid_i      (b_valid_q),
    .blk_i            (b_blk_q),
    .blk_take_o       (blk_take),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .target_address_o (target_address_o),
    .pixel_value_o    (pixel_value_o),
    .last_of_block_o  (last_of_block_o)
  );

  // zero pixels never enter the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_i && pixel_ready_o && pixel_word_i == '0) |=> !a_valid_q)
    else $error("zero pixel entered pipeline");

  // a block is not cut short before its flagged write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_block_o) |=>
      (out_valid_o && $stable(pixel_value_o)))
    else $error("block ended without last write");

  // input backpressure only when both internal stages are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_ready_o |-> (a_valid_q && b_valid_q))
    else $error("input stalled with free stage");

endmodule

@@ src/nnus_emitter.sv @@
`timescale 1ns / 1ps

module nnus_emitter #(
  parameter int unsigned MAX_SCALE = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [nnus_pkg::ScaleW-1:0]     scale_i,
  input  logic                            blk_valid_i,
  input  nnus_pkg::blk_t                  blk_i,
  output logic                            blk_take_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nnus_pkg::AddrW-1:0]      target_address_o,
  output logic [nnus_pkg::PixelW-1:0]     pixel_value_o,
  output logic                            last_of_block_o
);

  localparam int unsigned SW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic                          valid_q;
  logic [SW-1:0]                 i_q, i_d;
  logic [SW-1:0]                 j_q, j_d;
  logic [nnus_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [nnus_pkg::AddrW-1:0]    row_q, row_d;
  logic [nnus_pkg::AddrW-1:0]    tw_q, tw_d;
  logic [nnus_pkg::PixelW-1:0]   pix_q, pix_d;
  logic                          last_col;
  logic                          last_row;
  logic                          step;
  logic                          done;
  logic                          take;

  assign last_col = (nnus_pkg::ScaleW'(j_q) == (scale_i - nnus_pkg::ScaleW'(1)));
  assign last_row = (nnus_pkg::ScaleW'(i_q) == (scale_i - nnus_pkg::ScaleW'(1)));
  assign step     = valid_q & out_ready_i;
  assign done     = step & last_col & last_row;
  assign take     = blk_valid_i & (~valid_q | done);

  assign blk_take_o       = take;
  assign out_valid_o      = valid_q;
  assign target_address_o = addr_q;
  assign pixel_value_o    = pix_q;
  assign last_of_block_o  = last_col & last_row;

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    addr_d = addr_q;
    row_d  = row_q;
    tw_d   = tw_q;
    pix_d  = pix_q;
    if (take) begin
      i_d    = '0;
      j_d    = '0;
      addr_d = blk_i.base;
      row_d  = blk_i.base;
      tw_d   = nnus_pkg::AddrW'(blk_i.tw);
      pix_d  = blk_i.pix;
    end else if (step && !done) begin
      if (last_col) begin
        j_d    = '0;
        i_d    = SW'(i_q + 1'b1);
        row_d  = row_q + tw_q;
        addr_d = row_q + tw_q;
      end else begin
        j_d    = SW'(j_q + 1'b1);
        addr_d = addr_q + nnus_pkg::AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (done) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    addr_q <= addr_d;
    row_q  <= row_d;
    tw_q   <= tw_d;
    pix_q  <= pix_d;
  end

endmodule
